FILE: src/giflzw_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Shared widths, the packer status group and the output item type.
// ----------------------------------------------------------------------------
package giflzw_pkg;

	localparam int CODE_W = 12;
	localparam int ACC_W  = 19;
	localparam int NB_W   = 5;
	localparam int QDEPTH = 8;

	typedef struct packed {
		logic drained;
		logic empty;
	} pack_stat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

endpackage

FILE: src/giflzw_pack.sv
// ----------------------------------------------------------------------------
// GIF LZW bit packer
// Packs variable-width codes LSB-first and releases one byte per cycle while byte_ready is held high.
// ----------------------------------------------------------------------------
module giflzw_pack import giflzw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              code_valid,
	output logic              code_ready,
	input  logic [CODE_W-1:0] code,
	input  logic [3:0]        code_width,
	input  logic              flush,
	output logic              byte_valid,
	input  logic              byte_ready,
	output logic [7:0]        byte_data,
	output pack_stat_t        stat
);

	logic [ACC_W-1:0]  acc_q;
	logic [NB_W-1:0]   nb_q;
	logic              full;
	logic [CODE_W-1:0] code_m;

	assign full        = (nb_q >= NB_W'(8));
	assign byte_valid  = full || (flush && (nb_q != '0));
	assign byte_data   = acc_q[7:0];
	assign code_ready  = !full && !flush;
	assign code_m      = code & ~({CODE_W{1'b1}} << code_width);
	assign stat.drained = !full;
	assign stat.empty   = (nb_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			nb_q  <= '0;
		end else if (byte_valid && byte_ready) begin
			acc_q <= acc_q >> 8;
			nb_q  <= full ? (nb_q - NB_W'(8)) : '0;
		end else if (code_valid && code_ready) begin
			acc_q <= acc_q | (ACC_W'(code_m) << nb_q);
			nb_q  <= nb_q + NB_W'(code_width);
		end
	end

endmodule

FILE: src/giflzw_cell.sv
// ----------------------------------------------------------------------------
// GIF LZW output cell
// One slot of the output queue; hands its item to the next cell.
// ----------------------------------------------------------------------------
module giflzw_cell import giflzw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  out_item_t up_data,
	output logic      dn_valid,
	input  logic      dn_ready,
	output out_item_t dn_data
);

	logic      v_q;
	out_item_t d_q;

	assign up_ready = !v_q || dn_ready;
	assign dn_valid = v_q;
	assign dn_data  = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q <= up_data;
		end
	end

endmodule

FILE: src/gif_lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder
// Dictionary search over per-code child lists, bit packer, output cell row.
// ----------------------------------------------------------------------------
// One pixel per item. The first item of an image also emits the clear code.
// The search walks the child list of the current code in the entry memory,
// one entry a cycle. After reset the block runs a clearing pass over all
// DICT_ENTRIES entries of the child-head memory before it takes the first
// item. Result bytes pass through a row of eight output cells.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_unit import giflzw_pkg::*; #(
	parameter int DICT_ENTRIES  = 4096,
	parameter int MAX_CODE_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] min_code_size,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       stream_end
);

	localparam int AW    = $clog2(DICT_ENTRIES);
	localparam int LIMIT = (DICT_ENTRIES < (1 << MAX_CODE_BITS)) ?
		DICT_ENTRIES : (1 << MAX_CODE_BITS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR0   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_FC     = 4'd3;
	localparam logic [3:0] S_ENT    = 4'd4;
	localparam logic [3:0] S_MISS   = 4'd5;
	localparam logic [3:0] S_CLR1   = 4'd6;
	localparam logic [3:0] S_TAIL   = 4'd7;
	localparam logic [3:0] S_END0   = 4'd8;
	localparam logic [3:0] S_END1   = 4'd9;
	localparam logic [3:0] S_PAD    = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	logic [3:0]        state_q;
	logic [3:0]        cfg_q;
	logic [3:0]        size_q;
	logic [3:0]        width_q;
	logic [12:0]       count_q;
	logic [CODE_W-1:0] cur_q;
	logic              have_q;
	logic              started_q;
	logic [7:0]        pix_q;
	logic              last_q;
	logic [CODE_W-1:0] cand_q;
	logic [CODE_W-1:0] link_q;
	logic              head_q;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;
	logic              held_v_q;
	logic [7:0]        held_q;

	logic [CODE_W-1:0] fc_mem   [DICT_ENTRIES];
	logic [CODE_W-1:0] pre_mem  [DICT_ENTRIES];
	logic [7:0]        byte_mem [DICT_ENTRIES];
	logic [CODE_W-1:0] sib_mem  [DICT_ENTRIES];
	logic [CODE_W-1:0] fc_rd_q;
	logic [CODE_W-1:0] pre_rd_q;
	logic [7:0]        byte_rd_q;
	logic [CODE_W-1:0] sib_rd_q;

	logic [3:0]        eff_size;
	logic [3:0]        size_n;
	logic [7:0]        pix_mask;
	logic [12:0]       first_code;
	logic [12:0]       first_eff;
	logic [CODE_W-1:0] clear_code;
	logic              in_fire;
	logic              code_valid;
	logic              code_ready;
	logic [CODE_W-1:0] code_val;
	logic              code_fire;
	logic              flush;
	logic              pk_valid;
	logic              pk_ready;
	logic [7:0]        pk_byte;
	pack_stat_t        pstat;
	logic              in_rng;
	logic              pmatch;
	logic              hit;
	logic              fc_re;
	logic [AW-1:0]     fc_raddr;
	logic              ent_re;
	logic [AW-1:0]     ent_raddr;
	logic              ent_we;
	logic              fc_we;
	logic [AW-1:0]     fc_waddr;
	logic [CODE_W-1:0] fc_wdata;
	logic [12:0]       count_inc;
	logic [3:0]        width_n;
	logic              done_push;
	logic              q_valid [QDEPTH+1];
	logic              q_ready [QDEPTH+1];
	out_item_t         q_data  [QDEPTH+1];

	assign cfg_ready = 1'b1;

	assign eff_size   = (cfg_q < 4'd2) ? 4'd2 : ((cfg_q > 4'd8) ? 4'd8 : cfg_q);
	assign size_n     = started_q ? size_q : eff_size;
	assign pix_mask   = 8'((9'd1 << size_n) - 9'd1);
	assign first_code = (13'd1 << size_q) + 13'd2;
	assign first_eff  = (13'd1 << eff_size) + 13'd2;
	assign clear_code = CODE_W'(13'd1 << size_q);

	assign in_ready = (state_q == S_IDLE) && !clr_busy_q;
	assign in_fire  = in_valid && in_ready;

	assign in_rng = (13'(cand_q) >= first_code) && (13'(cand_q) < count_q);
	assign pmatch = (pre_rd_q == cur_q);
	assign hit    = in_rng && pmatch && (byte_rd_q == pix_q);

	assign code_valid = (state_q == S_CLR0) || (state_q == S_MISS) ||
		(state_q == S_CLR1) || (state_q == S_END0) || (state_q == S_END1);
	assign code_fire  = code_valid && code_ready;
	assign flush      = (state_q == S_PAD);

	always_comb begin
		case (state_q)
			S_CLR0, S_CLR1: code_val = clear_code;
			S_END1:         code_val = clear_code + CODE_W'(1);
			default:        code_val = cur_q;
		endcase
	end

	assign count_inc = count_q + 13'd1;
	assign width_n   = ((count_q == (13'd1 << width_q)) &&
		(width_q < 4'(MAX_CODE_BITS))) ? (width_q + 4'd1) : width_q;

	assign fc_re     = (state_q == S_DECIDE) && have_q;
	assign fc_raddr  = cur_q[AW-1:0];
	assign ent_re    = (state_q == S_FC) || (state_q == S_ENT);
	assign ent_raddr = (state_q == S_FC) ? fc_rd_q[AW-1:0] : sib_rd_q[AW-1:0];
	assign ent_we    = (state_q == S_MISS) && code_fire &&
		(count_q < 13'(DICT_ENTRIES));
	assign fc_we     = clr_busy_q || ent_we;
	assign fc_waddr  = clr_busy_q ? clr_addr_q : cur_q[AW-1:0];
	assign fc_wdata  = clr_busy_q ? '0 : count_q[CODE_W-1:0];

	always_ff @(posedge clk) begin
		if (fc_we) begin
			fc_mem[fc_waddr] <= fc_wdata;
		end
		if (fc_re) begin
			fc_rd_q <= fc_mem[fc_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			pre_mem[count_q[AW-1:0]]  <= cur_q;
			byte_mem[count_q[AW-1:0]] <= pix_q;
			sib_mem[count_q[AW-1:0]]  <= link_q;
		end
		if (ent_re) begin
			pre_rd_q  <= pre_mem[ent_raddr];
			byte_rd_q <= byte_mem[ent_raddr];
			sib_rd_q  <= sib_mem[ent_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DICT_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= min_code_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			size_q    <= 4'd8;
			width_q   <= 4'd9;
			count_q   <= 13'd258;
			cur_q     <= '0;
			have_q    <= 1'b0;
			started_q <= 1'b0;
			pix_q     <= '0;
			last_q    <= 1'b0;
			cand_q    <= '0;
			link_q    <= '0;
			head_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pix_q  <= pixel & pix_mask;
						last_q <= last_pixel;
						if (!started_q) begin
							size_q    <= eff_size;
							width_q   <= eff_size + 4'd1;
							count_q   <= first_eff;
							have_q    <= 1'b0;
							cur_q     <= '0;
							started_q <= 1'b1;
							state_q   <= S_CLR0;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_CLR0: begin
					if (code_fire) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!have_q) begin
						cur_q   <= CODE_W'(pix_q);
						have_q  <= 1'b1;
						state_q <= S_TAIL;
					end else begin
						state_q <= S_FC;
					end
				end
				S_FC: begin
					cand_q  <= fc_rd_q;
					head_q  <= 1'b1;
					state_q <= S_ENT;
				end
				S_ENT: begin
					head_q <= 1'b0;
					if (head_q) begin
						link_q <= (in_rng && pmatch) ? cand_q : '0;
					end
					if (hit) begin
						cur_q   <= cand_q;
						state_q <= S_TAIL;
					end else if (in_rng && pmatch && (sib_rd_q != '0)) begin
						cand_q <= sib_rd_q;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (code_fire) begin
						width_q <= width_n;
						cur_q   <= CODE_W'(pix_q);
						count_q <= count_inc;
						state_q <= (count_inc >= 13'(LIMIT)) ? S_CLR1 : S_TAIL;
					end
				end
				S_CLR1: begin
					if (code_fire) begin
						width_q <= size_q + 4'd1;
						count_q <= first_code;
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= last_q ? S_END0 : S_DONE;
				end
				S_END0: begin
					if (code_fire) begin
						state_q <= S_END1;
					end
				end
				S_END1: begin
					if (code_fire) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (pstat.empty) begin
						started_q <= 1'b0;
						have_q    <= 1'b0;
						cur_q     <= '0;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (pstat.drained && (!held_v_q || q_ready[0])) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	giflzw_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code_val),
		.code_width (width_q),
		.flush      (flush),
		.byte_valid (pk_valid),
		.byte_ready (pk_ready),
		.byte_data  (pk_byte),
		.stat       (pstat)
	);

	assign done_push = (state_q == S_DONE) && pstat.drained && held_v_q;
	assign pk_ready  = !held_v_q || q_ready[0];

	assign q_valid[0]           = (held_v_q && pk_valid) || done_push;
	assign q_data[0].data       = held_q;
	assign q_data[0].run_last   = done_push;
	assign q_data[0].stream_end = done_push && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_q   <= '0;
		end else if (pk_valid && pk_ready) begin
			held_v_q <= 1'b1;
			held_q   <= pk_byte;
		end else if (done_push && q_ready[0]) begin
			held_v_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
		giflzw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (q_valid[i]),
			.up_ready (q_ready[i]),
			.up_data  (q_data[i]),
			.dn_valid (q_valid[i+1]),
			.dn_ready (q_ready[i+1]),
			.dn_data  (q_data[i+1])
		);
	end

	assign q_ready[QDEPTH] = out_ready;
	assign out_valid       = q_valid[QDEPTH];
	assign out_byte        = q_data[QDEPTH].data;
	assign run_last        = q_data[QDEPTH].run_last;
	assign stream_end      = q_data[QDEPTH].stream_end;

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 13'(LIMIT))
		else $error("dictionary count beyond limit");

	a_width_cap: assert property (@(posedge clk) disable iff (!arst_n)
		width_q <= 4'(MAX_CODE_BITS) || (width_q == size_q + 4'd1))
		else $error("code width beyond cap");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("item taken during clearing pass");

	a_held_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done_push && q_ready[0]) |=> !held_v_q && (state_q == S_IDLE))
		else $error("held byte not released at item end");

endmodule
